// ===== sv/rtbs_pkg.sv =====
// shared types and constants for the regression tree best split core
`timescale 1ns / 1ps
package rtbs_pkg;

  localparam int SUM_W        = 28;
  localparam int CNT_W        = 13;
  localparam int FEAT_W       = 16;
  localparam int TARG_W       = 16;
  localparam int VAR_W        = 6;
  localparam int SPLIT_W      = 17;
  localparam int SCORE_W      = 64;
  localparam int RAND_W       = 32;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 28;
  localparam int MAX_VARS_DEF = 64;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_SUM   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b1;

  localparam logic [CNT_W-1:0]  TIE_MAX    = '1;
  localparam logic [SCORE_W-1:0] RAND_FULL = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic                     start_search;
    logic                     first_of_var;
    logic [VAR_W-1:0]         var_number;
    logic [FEAT_W-1:0]        feature_value;
    logic signed [TARG_W-1:0] target_value;
    logic                     in_node;
    logic [RAND_W-1:0]        rand_word;
    logic                     last_item;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [VAR_W-1:0]   best_var;
    logic [SPLIT_W-1:0] split_twice;
    logic [SCORE_W-1:0] best_score;
  } out_item_t;

  // one queued piece of work for the back end
  typedef struct packed {
    logic                    start;
    logic                    score_ok;
    logic                    last;
    logic signed [SUM_W-1:0] lo_sum;
    logic signed [SUM_W:0]   hi_sum;
    logic [CNT_W-1:0]        n_lo;
    logic [CNT_W-1:0]        n_hi;
    logic [VAR_W-1:0]        var_number;
    logic [SPLIT_W-1:0]      split;
    logic [RAND_W-1:0]       rand_word;
  } job_t;

  typedef struct packed {
    logic done;
    logic busy;
  } div_stat_t;

endpackage

// ===== sv/regression_tree_best_split_core.sv =====
// top level of the regression tree best split core
`timescale 1ns / 1ps
// Best split search for one regression tree node. Observations stream in column by column,
// ascending in feature value within a column; each in-node row is folded into the rolling
// lower-side sums by the front end, and where the feature value changes a candidate split
// is placed in a four-entry queue. The back end scores each candidate as sum_lo^2/n_lo +
// sum_hi^2/n_hi, using one bit-serial divider for both quotients and for the random tie
// test on equal scores. Items that make no candidate are taken whenever the queue is not
// full; a candidate holds the shared divider for both quotients, and for the tie test on a
// tie, so input is stalled while the queue is full. The result item is produced after the
// item flagged last_item has passed through the back end. The user must write the node's
// target sum and count registers through the cfg port only while the core is idle; the
// core itself does not enforce this.
module regression_tree_best_split_core #(
  parameter int MAX_VARS = rtbs_pkg::MAX_VARS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rtbs_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rtbs_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rtbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtbs_pkg::CFG_DATA_W-1:0] cfg_data
);
  // queue between front and back end
  rtbs_pkg::job_t push_job, pop_job;
  logic q_push, q_pop, q_full, q_empty;

  // front end: row filtering, rolling sums, candidate forming
  rtbs_front #(.MAX_VARS(MAX_VARS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  rtbs_fifo #(.DEPTH(rtbs_pkg::QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_job),
    .pop       (q_pop),
    .pop_data  (pop_job),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back end: scoring, best tracking, tie breaking, result register
  rtbs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );
endmodule

// ===== sv/rtbs_fifo.sv =====
// small flip-flop queue between front and back end
`timescale 1ns / 1ps
module rtbs_fifo #(
  parameter int DEPTH = rtbs_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rtbs_pkg::job_t   push_data,
  input  logic             pop,
  output rtbs_pkg::job_t   pop_data,
  output logic             full,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rtbs_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [AW:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == (AW+1)'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == AW'(DEPTH-1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == AW'(DEPTH-1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end
endmodule

// ===== sv/rtbs_front.sv =====
// front end: config registers, rolling column sums and split candidates
`timescale 1ns / 1ps
module rtbs_front #(
  parameter int MAX_VARS = rtbs_pkg::MAX_VARS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rtbs_pkg::in_item_t                  in_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rtbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rtbs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                q_full,
  output logic                                q_push,
  output rtbs_pkg::job_t                      q_job
);
  localparam int SW = rtbs_pkg::SUM_W;
  localparam int CW = rtbs_pkg::CNT_W;

  logic [SW-1:0] nts_r;
  logic [CW-1:0] ncnt_r;
  logic [SW-1:0] moved_sum_r, moved_sum_nxt;
  logic [CW-1:0] moved_count_r, moved_count_nxt;
  logic [rtbs_pkg::FEAT_W-1:0] prev_feat_r, prev_feat_nxt;
  logic [rtbs_pkg::TARG_W-1:0] prev_targ_r, prev_targ_nxt;
  logic have_prev_r, have_prev_nxt;

  logic accept, restart, row, score_ok;
  logic [SW-1:0] ms, ms_new;
  logic [CW-1:0] mc, mc_new;
  logic hp;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  always_comb begin
    restart = in_data.start_search || in_data.first_of_var;
    ms      = restart ? '0 : moved_sum_r;
    mc      = restart ? '0 : moved_count_r;
    hp      = restart ? 1'b0 : have_prev_r;
    row     = in_data.in_node && (32'(in_data.var_number) < 32'(MAX_VARS));
    ms_new  = ms + {{(SW-rtbs_pkg::TARG_W){prev_targ_r[rtbs_pkg::TARG_W-1]}}, prev_targ_r};
    mc_new  = mc + 1'b1;
    score_ok = row && hp && (in_data.feature_value != prev_feat_r);

    moved_sum_nxt   = ms;
    moved_count_nxt = mc;
    prev_feat_nxt   = restart ? '0 : prev_feat_r;
    prev_targ_nxt   = restart ? '0 : prev_targ_r;
    have_prev_nxt   = hp;
    if (row) begin
      if (hp) begin
        moved_sum_nxt   = ms_new;
        moved_count_nxt = mc_new;
      end
      prev_feat_nxt = in_data.feature_value;
      prev_targ_nxt = in_data.target_value;
      have_prev_nxt = 1'b1;
    end

    q_job.start      = in_data.start_search;
    q_job.score_ok   = score_ok;
    q_job.last       = in_data.last_item;
    q_job.lo_sum     = ms_new;
    q_job.hi_sum     = $signed({nts_r[SW-1], nts_r}) - $signed({ms_new[SW-1], ms_new});
    q_job.n_lo       = mc_new;
    q_job.n_hi       = (ncnt_r > mc_new) ? ncnt_r - mc_new : '0;
    q_job.var_number = in_data.var_number;
    q_job.split      = {1'b0, prev_feat_r} + {1'b0, in_data.feature_value};
    q_job.rand_word  = in_data.rand_word;
    q_push = accept && (in_data.start_search || score_ok || in_data.last_item);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nts_r         <= '0;
      ncnt_r        <= '0;
      moved_sum_r   <= '0;
      moved_count_r <= '0;
      prev_feat_r   <= '0;
      prev_targ_r   <= '0;
      have_prev_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          rtbs_pkg::CFG_NODE_SUM:   nts_r  <= cfg_data;
          rtbs_pkg::CFG_NODE_COUNT: ncnt_r <= cfg_data[CW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        moved_sum_r   <= moved_sum_nxt;
        moved_count_r <= moved_count_nxt;
        prev_feat_r   <= prev_feat_nxt;
        prev_targ_r   <= prev_targ_nxt;
        have_prev_r   <= have_prev_nxt;
      end
    end
  end
endmodule

// ===== sv/rtbs_div.sv =====
// bit-serial restoring divider, 64-bit dividend by 13-bit divisor
`timescale 1ns / 1ps
module rtbs_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [rtbs_pkg::SCORE_W-1:0]      dividend,
  input  logic [rtbs_pkg::CNT_W-1:0]        divisor,
  output rtbs_pkg::div_stat_t               stat,
  output logic [rtbs_pkg::SCORE_W-1:0]      quotient
);
  localparam int QW = rtbs_pkg::SCORE_W;
  localparam int DW = rtbs_pkg::CNT_W;
  localparam int CTW = $clog2(QW);

  logic [CTW-1:0] cnt_r;
  logic           busy_r, done_r;
  logic [DW-1:0]  rem_r, dvs_r;
  logic [QW-1:0]  quo_r;
  logic [DW:0]    trial, diff;
  logic           take;

  always_comb begin
    trial = {rem_r, quo_r[QW-1]};
    diff  = trial - {1'b0, dvs_r};
    take  = (trial >= {1'b0, dvs_r});
  end

  assign quotient  = quo_r;
  assign stat.done = done_r;
  assign stat.busy = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CTW'(QW-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start && !busy_r) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= take ? diff[DW-1:0] : trial[DW-1:0];
      quo_r <= {quo_r[QW-2:0], take};
    end
  end
endmodule

// ===== sv/rtbs_back.sv =====
// back end: split scoring, best split tracking and result register
`timescale 1ns / 1ps
module rtbs_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  rtbs_pkg::job_t       q_job,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rtbs_pkg::out_item_t  out_data
);
  localparam int QW = rtbs_pkg::SCORE_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SQ     = 7'b0000010,
    S_LAUNCH = 7'b0000100,
    S_WAIT   = 7'b0001000,
    S_DECIDE = 7'b0010000,
    S_EMIT   = 7'b0100000,
    S_HOLD   = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    PH_LO  = 3'b001,
    PH_HI  = 3'b010,
    PH_TIE = 3'b100
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  rtbs_pkg::job_t job_r;

  logic [QW-1:0] sq_lo_r, sq_hi_r, score_r, score_nxt;
  logic [QW-1:0] best_score_r, best_score_nxt;
  logic [rtbs_pkg::VAR_W-1:0]   best_var_r, best_var_nxt;
  logic [rtbs_pkg::SPLIT_W-1:0] best_split_r, best_split_nxt;
  logic found_r, found_nxt;
  logic [rtbs_pkg::CNT_W-1:0] tie_r, tie_nxt;
  logic out_valid_r, out_valid_nxt;
  rtbs_pkg::out_item_t out_r;

  logic div_start;
  logic [QW-1:0] div_dvd;
  logic [rtbs_pkg::CNT_W-1:0] div_dvs;
  rtbs_pkg::div_stat_t div_stat;
  logic [QW-1:0] div_q;

  logic [rtbs_pkg::SUM_W-1:0] abs_lo;
  logic [rtbs_pkg::SUM_W:0]   abs_hi;
  logic out_free, load_out;

  rtbs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .stat     (div_stat),
    .quotient (div_q)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    abs_lo = job_r.lo_sum[rtbs_pkg::SUM_W-1] ? -job_r.lo_sum : job_r.lo_sum;
    abs_hi = job_r.hi_sum[rtbs_pkg::SUM_W]   ? -job_r.hi_sum : job_r.hi_sum;
  end

  always_comb begin
    unique case (phase_r)
      PH_LO:   begin div_dvd = sq_lo_r;              div_dvs = job_r.n_lo; end
      PH_HI:   begin div_dvd = sq_hi_r;              div_dvs = job_r.n_hi; end
      PH_TIE:  begin div_dvd = rtbs_pkg::RAND_FULL;  div_dvs = tie_r;      end
      default: begin div_dvd = sq_lo_r;              div_dvs = job_r.n_lo; end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    score_nxt      = score_r;
    best_score_nxt = best_score_r;
    best_var_nxt   = best_var_r;
    best_split_nxt = best_split_r;
    found_nxt      = found_r;
    tie_nxt        = tie_r;
    q_pop          = 1'b0;
    div_start      = 1'b0;
    load_out       = 1'b0;
    out_valid_nxt  = out_valid_r && out_stall;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_job.start) begin
            best_score_nxt = '0;
            best_var_nxt   = '0;
            best_split_nxt = '0;
            found_nxt      = 1'b0;
            tie_nxt        = '0;
          end
          if (q_job.score_ok) begin
            state_nxt = S_SQ;
          end else if (q_job.last) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_SQ: begin
        phase_nxt = PH_LO;
        state_nxt = S_LAUNCH;
      end
      S_LAUNCH: begin
        div_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_stat.done) begin
          unique case (phase_r)
            PH_LO: begin
              score_nxt = (job_r.n_lo == '0) ? '0 : div_q;
              phase_nxt = PH_HI;
              state_nxt = S_LAUNCH;
            end
            PH_HI: begin
              score_nxt = score_r + ((job_r.n_hi == '0) ? '0 : div_q);
              state_nxt = S_DECIDE;
            end
            PH_TIE: begin
              if ({32'd0, job_r.rand_word} < div_q) begin
                best_var_nxt   = job_r.var_number;
                best_split_nxt = job_r.split;
              end
              state_nxt = S_HOLD;
            end
            default: state_nxt = S_HOLD;
          endcase
        end
      end
      S_DECIDE: begin
        state_nxt = S_HOLD;
        if (score_r != '0) begin
          if (found_r && score_r == best_score_r) begin
            if (tie_r != rtbs_pkg::TIE_MAX) begin
              tie_nxt = tie_r + 1'b1;
            end
            phase_nxt = PH_TIE;
            state_nxt = S_LAUNCH;
          end else if (!found_r || score_r > best_score_r) begin
            best_score_nxt = score_r;
            best_var_nxt   = job_r.var_number;
            best_split_nxt = job_r.split;
            tie_nxt        = rtbs_pkg::CNT_W'(1);
            found_nxt      = 1'b1;
          end
        end
      end
      S_HOLD: begin
        state_nxt = job_r.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (out_free) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_LO;
      out_valid_r  <= 1'b0;
      best_score_r <= '0;
      best_var_r   <= '0;
      best_split_r <= '0;
      found_r      <= 1'b0;
      tie_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      out_valid_r  <= out_valid_nxt;
      best_score_r <= best_score_nxt;
      best_var_r   <= best_var_nxt;
      best_split_r <= best_split_nxt;
      found_r      <= found_nxt;
      tie_r        <= tie_nxt;
    end
    score_r <= score_nxt;
    if (q_pop) begin
      job_r <= q_job;
    end
    if (state_r == S_SQ) begin
      sq_lo_r <= QW'(abs_lo) * QW'(abs_lo);
      sq_hi_r <= QW'(abs_hi) * QW'(abs_hi);
    end
    if (load_out) begin
      out_r.found       <= found_r;
      out_r.best_var    <= best_var_r;
      out_r.split_twice <= best_split_r;
      out_r.best_score  <= best_score_r;
    end
  end

  a_found_tie: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (tie_r != '0))
    else $error("best split held with zero tie count");

  a_clear_when_none: assert property (@(posedge clk) disable iff (!rst_n)
    !found_r |-> (best_score_r == '0 && best_var_r == '0 && best_split_r == '0))
    else $error("best split fields not clear without a split");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE && !q_empty))
    else $error("queue popped outside idle");
endmodule
